// ===== rtl/fvp_pkg.sv =====
// Shared types and constants for the FLV AVC video tag parser.
// Used by fvp_front, fvp_fifo, fvp_back and the top level; no dependencies.
`timescale 1ns / 1ps
package fvp_pkg;

  localparam logic [3:0] CodecAvc     = 4'd7;
  localparam logic [7:0] PktSeqHeader = 8'd0;
  localparam logic [7:0] PktNalu      = 8'd1;
  localparam logic [3:0] CodecMask    = 4'hf;
  localparam logic [1:0] SizeMask     = 2'h3;
  localparam logic [4:0] CountMask    = 5'h1f;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_NOT_AVC   = 3'd2,
    ST_BAD_COUNT = 3'd3,
    ST_NO_SEQ    = 3'd4,
    ST_ANNEX_B   = 3'd5,
    ST_TOO_MANY  = 3'd6
  } status_e;

  // Everything one byte can cause: an optional unit descriptor and an
  // optional summary, sharing the tag context.
  typedef struct packed {
    logic        unit_valid;
    logic        sum_valid;
    logic [23:0] unit_offset;
    logic [30:0] unit_length;
    status_e     status;
    logic [3:0]  frame_kind;
    logic [7:0]  packet_kind;
    logic [23:0] cts_offset;
    logic [7:0]  units_found;
    logic [7:0]  profile;
    logic [7:0]  level;
    logic [2:0]  prefix_bytes;
  } entry_t;

endpackage

// ===== rtl/flv_avc_video_tag_parser_top.sv =====
// FLV AVC video tag parser, top level: front parser, entry queue, output stage.
// Depends on fvp_pkg, fvp_front, fvp_fifo and fvp_back.
//
// Feed the body of one FLV video tag a byte per item on s_axis, with tlast on
// its final byte. The block accepts one byte per cycle while the entry queue
// has room; a byte that yields both a NAL unit descriptor and the end-of-tag
// summary gives two results on the output, descriptor first, so with
// m_axis_tready high the sustained rate is one byte a cycle except for those
// bytes. Descriptors carry each unit's payload offset and length; the summary
// carries the tag status, frame and packet kind, composition time and unit
// count. tlast on m_axis marks the final result of an input byte, tuser the
// result kind (0 descriptor, 1 summary). MAX_UNITS caps descriptors per tag;
// FIFO_DEPTH sets the queue between parser and output.
`timescale 1ns / 1ps
module flv_avc_video_tag_parser_top import fvp_pkg::*; #(
  parameter int unsigned MAX_UNITS  = 128,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] tag_byte
  input  logic         s_axis_tlast,   // end_of_tag
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [23:0] unit_offset, [54:24] unit_length, [57:55] status,
  // [61:58] frame_kind, [69:62] packet_kind, [93:70] composition time offset,
  // [101:94] units_found, [109:102] avc_profile_out, [117:110] avc_level_out,
  // [120:118] prefix_bytes, [127:121] zero
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tuser,   // kind
  output logic         m_axis_tlast    // last_of_run
);

  entry_t push_entry, head_entry, cur;
  logic   push, pop, full, empty, accept, kind;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  fvp_front #(.MAX_UNITS(MAX_UNITS)) u_front (
    .clk_i, .rst_ni,
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .eot_i    (s_axis_tlast),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  fvp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  fvp_back u_back (
    .clk_i, .rst_ni,
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .kind_o  (kind),
    .last_o  (m_axis_tlast),
    .cur_o   (cur)
  );

  // Zero the unit fields in a summary, the status in a descriptor.
  assign m_axis_tuser = kind;
  assign m_axis_tdata = {7'd0, cur.prefix_bytes, cur.level, cur.profile,
                         cur.units_found, cur.cts_offset, cur.packet_kind,
                         cur.frame_kind,
                         kind ? cur.status : ST_OK,
                         kind ? 31'd0 : cur.unit_length,
                         kind ? 24'd0 : cur.unit_offset};

endmodule

// ===== rtl/fvp_front.sv =====
// Front end: parses tag bytes and builds a result entry for each byte that yields a unit or ends the tag.
// Depends on fvp_pkg.
`timescale 1ns / 1ps
module fvp_front import fvp_pkg::*; #(
  parameter int unsigned MAX_UNITS = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  output logic       push_o,
  output entry_t     entry_o
);

  typedef enum logic [3:0] {
    PH_FIRST, PH_HDR, PH_SEQ_FIXED, PH_SPS_COUNT, PH_SPS_LEN, PH_SPS_DATA,
    PH_PPS_COUNT, PH_PPS_LEN, PH_PPS_DATA, PH_TRAIL, PH_NAL_PREFIX,
    PH_NAL_DATA, PH_SKIP
  } phase_e;

  localparam logic [7:0] MaxUnits = 8'(MAX_UNITS);

  phase_e      phase_q, phase_d;
  logic [2:0]  fc_q, fc_d;
  logic [31:0] acc_q, acc_d;
  logic [30:0] left_q, left_d;
  logic [23:0] off_q, off_d;
  logic [3:0]  frame_q, frame_d;
  logic [7:0]  pkt_q, pkt_d;
  logic [23:0] cts_q, cts_d;
  status_e     st_q, st_d;
  logic [7:0]  units_q, units_d;
  logic        seen_q, seen_d;
  logic [1:0]  lsc_q, lsc_d;
  logic [7:0]  prof_q, prof_d;
  logic [7:0]  lvl_q, lvl_d;
  logic        unit_v;
  logic [23:0] unit_off;
  logic [30:0] unit_len;
  logic [31:0] acc_sh;
  logic [30:0] left_dec;
  logic [2:0]  fc_inc;
  status_e     sum_st;

  always_comb begin
    phase_d = phase_q; fc_d = fc_q; acc_d = acc_q; left_d = left_q;
    off_d = off_q; frame_d = frame_q; pkt_d = pkt_q; cts_d = cts_q;
    st_d = st_q; units_d = units_q; seen_d = seen_q; lsc_d = lsc_q;
    prof_d = prof_q; lvl_d = lvl_q;
    unit_v = 1'b0; unit_off = '0; unit_len = '0;
    acc_sh = {acc_q[23:0], byte_i};
    left_dec = left_q - 31'd1;
    fc_inc = fc_q + 3'd1;
    unique case (phase_q)
      PH_FIRST: begin
        frame_d = byte_i[7:4];
        if ((byte_i[3:0] & CodecMask) != CodecAvc) begin
          st_d = ST_NOT_AVC; phase_d = PH_SKIP;
        end else begin
          phase_d = PH_HDR; fc_d = '0;
        end
      end
      PH_HDR: begin
        if (fc_q == 3'd0) pkt_d = byte_i;
        else cts_d = {cts_q[15:0], byte_i};
        fc_d = fc_inc;
        if (fc_inc >= 3'd4) begin
          fc_d = '0; acc_d = '0;
          if (pkt_d == PktSeqHeader) begin
            seen_d = !eot_i; phase_d = PH_SEQ_FIXED;
          end else if (pkt_d == PktNalu) begin
            if (!seen_q) begin
              st_d = ST_NO_SEQ; phase_d = PH_SKIP;
            end else phase_d = PH_NAL_PREFIX;
          end else phase_d = PH_TRAIL;
        end
      end
      PH_SEQ_FIXED: begin
        // hold profile, level and prefix code until the SPS count byte
        if (fc_q == 3'd1) acc_d[15:8] = byte_i;
        else if (fc_q == 3'd3) acc_d[7:0] = byte_i;
        else if (fc_q == 3'd4) acc_d[17:16] = byte_i[1:0] & SizeMask;
        fc_d = fc_inc;
        if (fc_inc >= 3'd5) phase_d = PH_SPS_COUNT;
      end
      PH_SPS_COUNT, PH_PPS_COUNT: begin
        if (phase_q == PH_SPS_COUNT) begin
          prof_d = acc_q[15:8]; lvl_d = acc_q[7:0]; lsc_d = acc_q[17:16];
        end
        if ((byte_i[4:0] & CountMask) != 5'd1) begin
          st_d = ST_BAD_COUNT; phase_d = PH_SKIP;
        end else begin
          phase_d = (phase_q == PH_SPS_COUNT) ? PH_SPS_LEN : PH_PPS_LEN;
          fc_d = '0; acc_d = '0;
        end
      end
      PH_SPS_LEN, PH_PPS_LEN: begin
        acc_d = {16'd0, acc_q[7:0], byte_i};
        fc_d = fc_inc;
        if (fc_inc >= 3'd2) begin
          fc_d = '0;
          left_d = {15'd0, acc_d[15:0]};
          if (acc_d[15:0] == 16'd0)
            phase_d = (phase_q == PH_SPS_LEN) ? PH_PPS_COUNT : PH_TRAIL;
          else
            phase_d = (phase_q == PH_SPS_LEN) ? PH_SPS_DATA : PH_PPS_DATA;
        end
      end
      PH_SPS_DATA, PH_PPS_DATA: begin
        left_d = left_dec;
        if (left_dec == '0)
          phase_d = (phase_q == PH_SPS_DATA) ? PH_PPS_COUNT : PH_TRAIL;
      end
      PH_NAL_PREFIX: begin
        acc_d = acc_sh;
        fc_d = fc_inc;
        if (fc_inc == {1'b0, lsc_q} + 3'd1) begin
          fc_d = '0;
          if (lsc_q == 2'd3 && acc_sh[31]) begin
            st_d = ST_ANNEX_B; phase_d = PH_SKIP;
          end else if (acc_sh == '0) begin
            if (units_q >= MaxUnits) begin
              st_d = ST_TOO_MANY; phase_d = PH_SKIP;
            end else begin
              units_d = units_q + 8'd1;
              unit_v = 1'b1; unit_off = off_q + 24'd1;
            end
          end else begin
            left_d = acc_sh[30:0]; phase_d = PH_NAL_DATA;
          end
        end
      end
      PH_NAL_DATA: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = PH_NAL_PREFIX; fc_d = '0; acc_d = '0;
          if (units_q >= MaxUnits) begin
            st_d = ST_TOO_MANY; phase_d = PH_SKIP;
          end else begin
            units_d = units_q + 8'd1;
            unit_v = 1'b1;
            unit_len = acc_q[30:0];
            unit_off = off_q - acc_q[23:0] + 24'd1;
          end
        end
      end
      PH_TRAIL, PH_SKIP: ;
      default: ;
    endcase

    sum_st = st_d;
    if (st_d == ST_OK && !(phase_d == PH_TRAIL ||
        (phase_d == PH_NAL_PREFIX && fc_d == 3'd0)))
      sum_st = ST_TRUNC;

    entry_o.unit_valid       = unit_v;
    entry_o.sum_valid        = eot_i;
    entry_o.unit_offset      = unit_off;
    entry_o.unit_length      = unit_len;
    entry_o.status           = sum_st;
    entry_o.frame_kind       = frame_d;
    entry_o.packet_kind      = pkt_d;
    entry_o.cts_offset       = cts_d;
    entry_o.units_found      = units_d;
    entry_o.profile          = prof_d;
    entry_o.level            = lvl_d;
    entry_o.prefix_bytes     = {1'b0, lsc_d} + 3'd1;
    push_o = accept_i && (unit_v || eot_i);

    if (eot_i) begin
      phase_d = PH_FIRST; fc_d = '0; acc_d = '0; left_d = '0; off_d = '0;
      frame_d = '0; pkt_d = '0; cts_d = '0; st_d = ST_OK; units_d = '0;
    end else begin
      off_d = off_q + 24'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST; fc_q <= '0; acc_q <= '0; left_q <= '0; off_q <= '0;
      frame_q <= '0; pkt_q <= '0; cts_q <= '0; st_q <= ST_OK; units_q <= '0;
      seen_q <= 1'b0; lsc_q <= '0; prof_q <= '0; lvl_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d; fc_q <= fc_d; acc_q <= acc_d; left_q <= left_d;
      off_q <= off_d; frame_q <= frame_d; pkt_q <= pkt_d; cts_q <= cts_d;
      st_q <= st_d; units_q <= units_d; seen_q <= seen_d; lsc_q <= lsc_d;
      prof_q <= prof_d; lvl_q <= lvl_d;
    end
  end

endmodule

// ===== rtl/fvp_fifo.sv =====
// Short entry queue between the front end and the output stage.
// Depends on fvp_pkg.
`timescale 1ns / 1ps
module fvp_fifo import fvp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/fvp_back.sv =====
// Output stage: takes queued entries and presents their results one a cycle while ready_i is high.
// Depends on fvp_pkg.
`timescale 1ns / 1ps
module fvp_back import fvp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t entry_i,
  input  logic   empty_i,
  output logic   pop_o,
  input  logic   ready_i,
  output logic   valid_o,
  output logic   kind_o,
  output logic   last_o,
  output entry_t cur_o
);

  entry_t cur_q;
  logic   valid_q, sum_q;
  logic   done;

  assign valid_o = valid_q;
  assign kind_o  = sum_q;
  assign last_o  = sum_q || !cur_q.sum_valid;
  assign cur_o   = cur_q;
  assign done    = !valid_q || (ready_i && last_o);
  assign pop_o   = done && !empty_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0; sum_q <= 1'b0;
    end else if (done) begin
      valid_q <= !empty_i;
      sum_q   <= !entry_i.unit_valid;
    end else if (ready_i) begin
      // descriptor taken, summary of the same byte follows
      sum_q <= 1'b1;
    end
  end

endmodule
